FILE: src/buvg_pkg.sv
// Shared types, constants and codes for the battery undervoltage and stale-sample guard.
// Used by buvg_cfg_regs, buvg_core and battery_undervoltage_stale_guard.
`timescale 1ns / 1ps

package buvg_pkg;

  // Width of the internal time base; the tick input carries 32 bits.
  localparam int TimeW = 32;
  localparam int TickW = 32;
  localparam int SeqW = 32;
  localparam int VoltInW = 16;
  localparam int VoltW = 15;
  localparam int GraceW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  typedef logic [TimeW-1:0] time_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLowVoltage   = 2'd0,
    CfgStartupGrace = 2'd1,
    CfgMaxAge       = 2'd2,
    CfgLowGrace     = 2'd3
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [VoltW-1:0]  LowVoltageReset   = 15'd10400;
  localparam logic [GraceW-1:0] StartupGraceReset = 16'd3000;
  localparam logic [GraceW-1:0] MaxAgeReset       = 16'd5000;
  localparam logic [GraceW-1:0] LowGraceReset     = 16'd5000;

  // Request kinds.
  typedef enum logic {
    KindRestart = 1'b0,
    KindCheck   = 1'b1
  } kind_e;

  // Trip reasons.
  typedef enum logic [1:0] {
    ReasonNone  = 2'd0,
    ReasonUnder = 2'd1,
    ReasonStale = 2'd2
  } reason_e;

  typedef struct packed {
    logic [VoltW-1:0]  low_voltage_mv;
    logic [GraceW-1:0] startup_grace_ticks;
    logic [GraceW-1:0] max_sample_age_ticks;
    logic [GraceW-1:0] low_voltage_grace_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [TickW-1:0]    now_tick;
    logic                snapshot_valid;
    logic [SeqW-1:0]     sample_sequence;
    logic [VoltInW-1:0]  voltage_mv;
    logic                filter_ready;
  } item_t;

  typedef struct packed {
    logic             tripped;
    reason_e          trip_reason;
    logic [VoltW-1:0] trip_voltage_mv;
    logic             alarm_event;
  } result_t;

endpackage

FILE: src/buvg_cfg_regs.sv
// Configuration registers of the battery guard, written through a valid/ready port.
// Depends on buvg_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module buvg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [buvg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [buvg_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          cfg_ready_o,
  output buvg_pkg::cfg_t                cfg_o
);

  buvg_pkg::cfg_t cfg_q;

  // Writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  // Register file update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_voltage_mv          <= buvg_pkg::LowVoltageReset;
      cfg_q.startup_grace_ticks     <= buvg_pkg::StartupGraceReset;
      cfg_q.max_sample_age_ticks    <= buvg_pkg::MaxAgeReset;
      cfg_q.low_voltage_grace_ticks <= buvg_pkg::LowGraceReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (buvg_pkg::cfg_idx_e'(cfg_index_i))
        buvg_pkg::CfgLowVoltage: begin
          cfg_q.low_voltage_mv <= cfg_data_i[buvg_pkg::VoltW-1:0];
        end
        buvg_pkg::CfgStartupGrace: begin
          cfg_q.startup_grace_ticks <= cfg_data_i[buvg_pkg::GraceW-1:0];
        end
        buvg_pkg::CfgMaxAge: begin
          cfg_q.max_sample_age_ticks <= cfg_data_i[buvg_pkg::GraceW-1:0];
        end
        buvg_pkg::CfgLowGrace: begin
          cfg_q.low_voltage_grace_ticks <= cfg_data_i[buvg_pkg::GraceW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/buvg_core.sv
// Decision logic and alarm state of the battery guard: one request per cycle while fire_i is high.
// Depends on buvg_pkg for item_t, cfg_t, result_t and the code enums.
`timescale 1ns / 1ps

module buvg_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  buvg_pkg::item_t   item_i,
  input  buvg_pkg::cfg_t    cfg_i,
  output buvg_pkg::result_t result_o
);

  logic                       latched_q, latched_d;
  buvg_pkg::reason_e          reason_q, reason_d;
  logic [buvg_pkg::VoltW-1:0] volt_q, volt_d;
  logic [buvg_pkg::SeqW-1:0]  last_seq_q, last_seq_d;
  buvg_pkg::time_t            last_fresh_q, last_fresh_d;
  buvg_pkg::time_t            start_q, start_d;
  buvg_pkg::time_t            first_fresh_q, first_fresh_d;
  logic                       seen_q, seen_d;

  buvg_pkg::time_t            now;
  buvg_pkg::time_t            first_ref;
  buvg_pkg::time_t            since_first, since_start, since_fresh;
  logic [buvg_pkg::VoltW-1:0] volt_clamped;
  logic                       fresh, under_trip, stale_trip, event_d;

  // Time base and clamped voltage.
  assign now          = buvg_pkg::TimeW'(item_i.now_tick);
  assign volt_clamped = item_i.voltage_mv[buvg_pkg::VoltInW-1] ? '0
                      : item_i.voltage_mv[buvg_pkg::VoltW-1:0];

  // A new sequence number, or the first sample since restart, is fresh.
  assign fresh = item_i.snapshot_valid && (!seen_q || (item_i.sample_sequence != last_seq_q));

  // Elapsed times wrap with the time base. The first sample counts from now.
  assign first_ref   = seen_q ? first_fresh_q : now;
  assign since_first = now - first_ref;
  assign since_start = now - start_q;
  assign since_fresh = now - last_fresh_q;

  assign under_trip = item_i.filter_ready
                   && (since_first >= buvg_pkg::TimeW'(cfg_i.low_voltage_grace_ticks))
                   && (volt_clamped < cfg_i.low_voltage_mv);
  assign stale_trip = seen_q ? (since_fresh >= buvg_pkg::TimeW'(cfg_i.max_sample_age_ticks))
                             : (since_start >= buvg_pkg::TimeW'(cfg_i.startup_grace_ticks));

  // Next state of the guard for the current request.
  always_comb begin
    latched_d     = latched_q;
    reason_d      = reason_q;
    volt_d        = volt_q;
    last_seq_d    = last_seq_q;
    last_fresh_d  = last_fresh_q;
    start_d       = start_q;
    first_fresh_d = first_fresh_q;
    seen_d        = seen_q;
    event_d       = 1'b0;
    if (item_i.kind == buvg_pkg::KindRestart) begin
      latched_d     = 1'b0;
      reason_d      = buvg_pkg::ReasonNone;
      volt_d        = '0;
      last_seq_d    = '0;
      last_fresh_d  = now;
      start_d       = now;
      first_fresh_d = '0;
      seen_d        = 1'b0;
    end else if (!latched_q) begin
      if (fresh) begin
        last_seq_d   = item_i.sample_sequence;
        last_fresh_d = now;
        if (!seen_q) begin
          first_fresh_d = now;
          seen_d        = 1'b1;
        end
        if (under_trip) begin
          latched_d = 1'b1;
          reason_d  = buvg_pkg::ReasonUnder;
          volt_d    = volt_clamped;
          event_d   = 1'b1;
        end
      end else if (stale_trip) begin
        latched_d = 1'b1;
        reason_d  = buvg_pkg::ReasonStale;
        volt_d    = '0;
        event_d   = 1'b1;
      end
    end
  end

  // State registers advance only when a request passes this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q     <= 1'b0;
      reason_q      <= buvg_pkg::ReasonNone;
      volt_q        <= '0;
      last_seq_q    <= '0;
      last_fresh_q  <= '0;
      start_q       <= '0;
      first_fresh_q <= '0;
      seen_q        <= 1'b0;
    end else if (fire_i) begin
      latched_q     <= latched_d;
      reason_q      <= reason_d;
      volt_q        <= volt_d;
      last_seq_q    <= last_seq_d;
      last_fresh_q  <= last_fresh_d;
      start_q       <= start_d;
      first_fresh_q <= first_fresh_d;
      seen_q        <= seen_d;
    end
  end

  // The result reports the latch as it stands after this request.
  always_comb begin
    result_o.tripped         = latched_d;
    result_o.trip_reason     = reason_d;
    result_o.trip_voltage_mv = volt_d;
    result_o.alarm_event     = event_d;
  end

endmodule

FILE: src/battery_undervoltage_stale_guard.sv
// Top level of the battery guard: input register, decision stage, result register.
// Depends on buvg_pkg, buvg_cfg_regs and buvg_core.
//
//   Channel   Direction  Handshake                Payload
//   in        request    in_valid_i / in_stall_o  kind, now_tick, snapshot, sequence, voltage
//   out       result     out_valid_o / out_stall_i tripped, reason, trip voltage, event
//   cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Every request gives one result through the input and result registers; one request per cycle
// is sustained unless the output stalls, via the single decision stage between them.
// Reset clears the alarm state and loads the configuration defaults.
// in_stall_o rises only when the input register holds a request and the result
// register holds a result that the output side stalls.
`timescale 1ns / 1ps

module battery_undervoltage_stale_guard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [buvg_pkg::TickW-1:0]    now_tick_i,
  input  logic                          snapshot_valid_i,
  input  logic [buvg_pkg::SeqW-1:0]     sample_sequence_i,
  input  logic signed [buvg_pkg::VoltInW-1:0] voltage_mv_i,
  input  logic                          filter_ready_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          tripped_o,
  output logic [1:0]                    trip_reason_o,
  output logic [buvg_pkg::VoltW-1:0]    trip_voltage_mv_o,
  output logic                          alarm_event_o,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [buvg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [buvg_pkg::CfgDataW-1:0] cfg_data_i
);

  buvg_pkg::cfg_t    cfg;
  buvg_pkg::item_t   item_q;
  buvg_pkg::result_t result_d, result_q;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              fire;

  // Configuration registers.
  buvg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // The result register can load when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = item_valid_q && advance;
  assign in_stall_o = item_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.kind            <= buvg_pkg::kind_e'(kind_i);
      item_q.now_tick        <= now_tick_i;
      item_q.snapshot_valid  <= snapshot_valid_i;
      item_q.sample_sequence <= sample_sequence_i;
      item_q.voltage_mv      <= voltage_mv_i;
      item_q.filter_ready    <= filter_ready_i;
    end
  end

  // Decision stage with the alarm state.
  buvg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tripped_o         = result_q.tripped;
  assign trip_reason_o     = result_q.trip_reason;
  assign trip_voltage_mv_o = result_q.trip_voltage_mv;
  assign alarm_event_o     = result_q.alarm_event;

  // An alarm event always comes with the latch set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alarm_event_o) |-> tripped_o)
    else $error("alarm event without latched trip");

  // An idle latch reports no reason and no voltage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tripped_o) |->
      (trip_reason_o == buvg_pkg::ReasonNone && trip_voltage_mv_o == '0))
    else $error("reason or voltage reported without trip");

  // A stale trip latches no voltage, and a trip always has a reason.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tripped_o) |->
      ((trip_reason_o == buvg_pkg::ReasonUnder) ||
       (trip_reason_o == buvg_pkg::ReasonStale && trip_voltage_mv_o == '0)))
    else $error("inconsistent latched trip");

  // A request waiting behind a stalled result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && out_valid_q && out_stall_i) |=> (item_valid_q && $stable(item_q)))
    else $error("pending request lost under output stall");

endmodule

FILE: verif/buvg_tb_pkg.sv
// Scoreboard for the battery undervoltage and stale-sample guard testbench.
// Depends on buvg_pkg for the request, status and register index types.
`timescale 1ns / 1ps

package buvg_tb_pkg;

  import buvg_pkg::*;

  class guard_scoreboard;

    // Configuration as last written to the block.
    logic [VoltW-1:0]  low_mv;
    logic [GraceW-1:0] startup_grace;
    logic [GraceW-1:0] max_age;
    logic [GraceW-1:0] low_grace;

    // Alarm state of the block.
    logic              latched;
    reason_e           latched_reason;
    logic [VoltW-1:0]  latched_volt;
    logic [SeqW-1:0]   last_seq;
    time_t             last_fresh;
    time_t             start_tick;
    time_t             first_fresh;
    logic              seen_sample;

    result_t           expected_status[$];
    int                n_errors;

    function new();
      low_mv        = LowVoltageReset;
      startup_grace = StartupGraceReset;
      max_age       = MaxAgeReset;
      low_grace     = LowGraceReset;
      n_errors      = 0;
      clear_alarm(time_t'(0));
    endfunction

    function void clear_alarm(time_t now);
      latched        = 1'b0;
      latched_reason = ReasonNone;
      latched_volt   = '0;
      last_seq       = '0;
      last_fresh     = now;
      start_tick     = now;
      first_fresh    = '0;
      seen_sample    = 1'b0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgLowVoltage:   low_mv        = data[VoltW-1:0];
        CfgStartupGrace: startup_grace = data;
        CfgMaxAge:       max_age       = data;
        CfgLowGrace:     low_grace     = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Apply one accepted request to the alarm state and queue the status it gives.
    function void apply_request(item_t req);
      result_t          st;
      logic [VoltW-1:0] volt;
      time_t            now;
      time_t            elapsed;
      logic             fire;
      now  = req.now_tick;
      fire = 1'b0;
      if (req.kind == KindRestart) begin
        clear_alarm(now);
      end else if (!latched) begin
        if (req.snapshot_valid && (!seen_sample || req.sample_sequence != last_seq)) begin
          // Fresh sample: negative voltages count as zero.
          volt = req.voltage_mv[VoltInW-1] ? '0 : req.voltage_mv[VoltW-1:0];
          last_seq   = req.sample_sequence;
          last_fresh = now;
          if (!seen_sample) begin
            first_fresh = now;
            seen_sample = 1'b1;
          end
          elapsed = now - first_fresh;
          if (req.filter_ready && elapsed >= time_t'(low_grace) && volt < low_mv) begin
            latched        = 1'b1;
            latched_reason = ReasonUnder;
            latched_volt   = volt;
            fire           = 1'b1;
          end
        end else begin
          // No fresh sample: measure against restart or against the last fresh sample.
          if (!seen_sample) begin
            elapsed = now - start_tick;
            fire    = elapsed >= time_t'(startup_grace);
          end else begin
            elapsed = now - last_fresh;
            fire    = elapsed >= time_t'(max_age);
          end
          if (fire) begin
            latched        = 1'b1;
            latched_reason = ReasonStale;
            latched_volt   = '0;
          end
        end
      end
      st.tripped         = latched;
      st.trip_reason     = latched_reason;
      st.trip_voltage_mv = latched_volt;
      st.alarm_event     = fire;
      expected_status.push_back(st);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_errors++;
    endtask

    // Compare one accepted status with the oldest one outstanding.
    task check_result(result_t got);
      result_t want;
      if (expected_status.size() == 0) begin
        report("status arrived with no request outstanding");
        return;
      end
      want = expected_status.pop_front();
      if (got.tripped !== want.tripped)
        report($sformatf("tripped got %0b want %0b", got.tripped, want.tripped));
      if (got.trip_reason !== want.trip_reason)
        report($sformatf("trip_reason got %0d want %0d", got.trip_reason, want.trip_reason));
      if (got.trip_voltage_mv !== want.trip_voltage_mv)
        report($sformatf("trip_voltage_mv got %0d want %0d",
                         got.trip_voltage_mv, want.trip_voltage_mv));
      if (got.alarm_event !== want.alarm_event)
        report($sformatf("alarm_event got %0b want %0b", got.alarm_event, want.alarm_event));
    endtask

  endclass

endpackage

FILE: verif/tb_top.sv
// Top of the battery guard testbench: clock, reset, request and register drivers.
// Depends on buvg_pkg, buvg_tb_pkg and battery_undervoltage_stale_guard.
`timescale 1ns / 1ps

module tb_top;

  import buvg_pkg::*;
  import buvg_tb_pkg::*;

  localparam int WatchdogLimit  = 4000;
  localparam int ItemsPerPhase  = 205;
  localparam int NumPhases      = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  logic [TickW-1:0]     now_tick_i;
  logic                 snapshot_valid_i;
  logic [SeqW-1:0]      sample_sequence_i;
  logic [VoltInW-1:0]   voltage_mv_i;
  logic                 filter_ready_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 tripped_o;
  logic [1:0]           trip_reason_o;
  logic [VoltW-1:0]     trip_voltage_mv_o;
  logic                 alarm_event_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  guard_scoreboard sb;
  int    send_idle_pct;
  int    stall_pct;
  int    quiet_cycles;
  time_t gen_now;

  battery_undervoltage_stale_guard i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .now_tick_i        (now_tick_i),
    .snapshot_valid_i  (snapshot_valid_i),
    .sample_sequence_i (sample_sequence_i),
    .voltage_mv_i      (voltage_mv_i),
    .filter_ready_i    (filter_ready_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .tripped_o         (tripped_o),
    .trip_reason_o     (trip_reason_o),
    .trip_voltage_mv_o (trip_voltage_mv_o),
    .alarm_event_o     (alarm_event_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output side stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watch both channels at the rising edge; the watchdog ends a hung run.
  always @(posedge clk_i) begin
    item_t   req;
    result_t st;
    quiet_cycles = quiet_cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        req.kind            = kind_e'(kind_i);
        req.now_tick        = now_tick_i;
        req.snapshot_valid  = snapshot_valid_i;
        req.sample_sequence = sample_sequence_i;
        req.voltage_mv      = voltage_mv_i;
        req.filter_ready    = filter_ready_i;
        sb.apply_request(req);
        quiet_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        st.tripped         = tripped_o;
        st.trip_reason     = reason_e'(trip_reason_o);
        st.trip_voltage_mv = trip_voltage_mv_o;
        st.alarm_event     = alarm_event_o;
        sb.check_result(st);
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) quiet_cycles = 0;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("battery_undervoltage_stale_guard regression: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the rising edge that takes the request.
  task automatic send_request(input item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= req.kind;
    now_tick_i        <= req.now_tick;
    snapshot_valid_i  <= req.snapshot_valid;
    sample_sequence_i <= req.sample_sequence;
    voltage_mv_i      <= req.voltage_mv;
    filter_ready_i    <= req.filter_ready;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_fields(kind_e kind, time_t now, logic snap, logic [SeqW-1:0] seq,
                             logic [VoltInW-1:0] volt, logic ready);
    item_t req;
    req.kind            = kind;
    req.now_tick        = now;
    req.snapshot_valid  = snap;
    req.sample_sequence = seq;
    req.voltage_mv      = volt;
    req.filter_ready    = ready;
    @(negedge clk_i);
    send_request(req);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_cfg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait until every outstanding status has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [GraceW-1:0] pick_grace();
    case ($urandom_range(3))
      0:       return '0;
      1:       return GraceW'($urandom_range(1, 400));
      2:       return GraceW'($urandom_range(0, 65535));
      default: return '1;
    endcase
  endfunction

  task automatic program_phase(int mode);
    logic [CfgDataW-1:0] thr;
    logic [GraceW-1:0]   g_start;
    logic [GraceW-1:0]   g_age;
    logic [GraceW-1:0]   g_low;
    case (mode)
      0: begin
        thr     = {1'b0, LowVoltageReset};
        g_start = StartupGraceReset;
        g_age   = MaxAgeReset;
        g_low   = LowGraceReset;
      end
      1: begin
        thr = '0; g_start = '0; g_age = '0; g_low = '0;
      end
      2: begin
        thr = '1; g_start = '1; g_age = '1; g_low = '1;
      end
      3: begin
        thr     = CfgDataW'($urandom_range(0, 65535));
        g_start = GraceW'($urandom_range(0, 300));
        g_age   = GraceW'($urandom_range(0, 300));
        g_low   = GraceW'($urandom_range(0, 300));
      end
      default: begin
        thr     = CfgDataW'($urandom_range(0, 65535));
        g_start = pick_grace();
        g_age   = pick_grace();
        g_low   = pick_grace();
      end
    endcase
    write_cfg(CfgLowVoltage, thr);
    write_cfg(CfgStartupGrace, g_start);
    write_cfg(CfgMaxAge, g_age);
    write_cfg(CfgLowGrace, g_low);
  endtask

  // Mostly check requests among occasional restarts, with times aimed at the grace boundaries.
  function automatic item_t make_item();
    item_t              req;
    logic [GraceW-1:0]  grace;
    time_t              anchor;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      req.kind            = kind_e'($urandom_range(1));
      req.now_tick        = $urandom();
      req.snapshot_valid  = 1'($urandom_range(1));
      req.sample_sequence = $urandom();
      req.voltage_mv      = VoltInW'($urandom());
      req.filter_ready    = 1'($urandom_range(1));
      gen_now = req.now_tick;
      return req;
    end
    case ($urandom_range(2))
      0:       grace = sb.startup_grace;
      1:       grace = sb.max_age;
      default: grace = sb.low_grace;
    endcase
    case ($urandom_range(2))
      0:       anchor = sb.start_tick;
      1:       anchor = sb.last_fresh;
      default: anchor = sb.first_fresh;
    endcase
    case ($urandom_range(9))
      0, 1, 2: gen_now = gen_now + $urandom_range(0, 16);
      3, 4, 5: gen_now = gen_now + $urandom_range(0, 2 * int'(grace) + 2);
      6, 7:    gen_now = anchor + time_t'(grace) + $urandom_range(0, 2) - 1;
      8:       gen_now = $urandom();
      default: gen_now = gen_now - $urandom_range(0, 100);
    endcase
    req.now_tick = gen_now;
    if (pick < 16) begin
      // Restart: the other fields are don't-cares and stay random.
      req.kind            = KindRestart;
      req.snapshot_valid  = 1'($urandom_range(1));
      req.sample_sequence = $urandom();
      req.voltage_mv      = VoltInW'($urandom());
      req.filter_ready    = 1'($urandom_range(1));
      return req;
    end
    req.kind           = KindCheck;
    req.snapshot_valid = ($urandom_range(9) != 0);
    req.filter_ready   = ($urandom_range(7) != 0);
    case ($urandom_range(4))
      0, 1:    req.sample_sequence = sb.last_seq + 1;
      2:       req.sample_sequence = sb.last_seq;
      3:       req.sample_sequence = $urandom();
      default: req.sample_sequence = $urandom_range(1) ? '0 : '1;
    endcase
    case ($urandom_range(5))
      0, 1, 2: req.voltage_mv = {1'b0, sb.low_mv} + VoltInW'($urandom_range(0, 6)) - 16'd3;
      3:       req.voltage_mv = VoltInW'($urandom());
      4: begin
        case ($urandom_range(3))
          0:       req.voltage_mv = 16'h8000;
          1:       req.voltage_mv = 16'hFFFF;
          2:       req.voltage_mv = 16'h7FFF;
          default: req.voltage_mv = 16'h0000;
        endcase
      end
      default: req.voltage_mv = VoltInW'($urandom_range(0, 32767));
    endcase
    return req;
  endfunction

  initial begin
    item_t req;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    kind_i            = 1'b0;
    now_tick_i        = '0;
    snapshot_valid_i  = 1'b0;
    sample_sequence_i = '0;
    voltage_mv_i      = '0;
    filter_ready_i    = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CfgLowVoltage;
    cfg_data_i        = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    quiet_cycles      = 0;
    gen_now           = '0;
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration.
    // Startup grace across the tick wrap, then the latch holds.
    send_fields(KindRestart, 32'hFFFF_FF00, 1'b1, 32'h1234, 16'h0000, 1'b1);
    send_fields(KindCheck,   32'hFFFF_FF64, 1'b0, 32'h0,    16'h0000, 1'b1);
    send_fields(KindCheck,   32'h0000_0AB8, 1'b0, 32'h0,    16'h0000, 1'b1);
    send_fields(KindCheck,   32'h0000_0AB9, 1'b1, 32'h5,    16'h0000, 1'b1);
    // First sample with sequence zero is fresh; a repeat of it is not.
    send_fields(KindRestart, 32'h0,    1'b0, 32'h0, 16'h0000, 1'b0);
    send_fields(KindCheck,   32'd10,   1'b1, 32'h0, 16'h8000, 1'b1);
    send_fields(KindCheck,   32'd4000, 1'b1, 32'h0, 16'h0000, 1'b1);
    // Filter not ready, threshold equality, then a negative voltage trips.
    send_fields(KindCheck,   32'd5010, 1'b1, 32'h1, 16'd10399, 1'b0);
    send_fields(KindCheck,   32'd5010, 1'b1, 32'h2, 16'd10400, 1'b1);
    send_fields(KindCheck,   32'd5010, 1'b1, 32'h3, 16'hFFFF,  1'b1);
    // Sample age limit, one tick short and then reached.
    send_fields(KindRestart, 32'd100,  1'b1, 32'h9, 16'h7FFF, 1'b1);
    send_fields(KindCheck,   32'd100,  1'b1, 32'h7, 16'h7FFF, 1'b1);
    send_fields(KindCheck,   32'd5099, 1'b0, 32'h7, 16'h0000, 1'b1);
    send_fields(KindCheck,   32'd5100, 1'b0, 32'h7, 16'h0000, 1'b1);
    // Low-voltage grace across the wrap.
    send_fields(KindRestart, 32'hFFFF_FFFF, 1'b0, 32'h0,         16'h0000, 1'b0);
    send_fields(KindCheck,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'd10399, 1'b1);
    send_fields(KindCheck,   32'd4998,      1'b1, 32'h5,         16'd10399, 1'b1);
    send_fields(KindCheck,   32'd4999,      1'b1, 32'h6,         16'd10399, 1'b1);
    settle();

    // Zero graces and the highest threshold.
    program_phase(1);
    write_cfg(CfgLowVoltage, 16'hFFFF);
    send_fields(KindRestart, 32'd50, 1'b0, 32'h0, 16'h0000, 1'b0);
    send_fields(KindCheck,   32'd50, 1'b0, 32'h0, 16'h0000, 1'b0);
    send_fields(KindRestart, 32'd60, 1'b0, 32'h0, 16'h0000, 1'b0);
    send_fields(KindCheck,   32'd60, 1'b1, 32'h1, 16'h7FFF, 1'b1);
    send_fields(KindCheck,   32'd61, 1'b1, 32'h2, 16'd32766, 1'b1);
    gen_now = 32'd61;
    settle();

    // Random phases: every configuration kind, every idling pattern.
    for (int p = 0; p < NumPhases; p++) begin
      program_phase(p);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 57; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        @(negedge clk_i);
        req = make_item();
        send_request(req);
      end
      settle();
    end

    stall_pct = 0;
    repeat (8) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d statuses never arrived", sb.pending()));
    if (sb.n_errors == 0) begin
      $display("battery_undervoltage_stale_guard regression: pass");
    end else begin
      $display("battery_undervoltage_stale_guard regression: fail");
    end
    $finish;
  end

endmodule
